// ----- design/vtp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtp_pkg
// Shared widths, codes, colors, config record and helper functions of the
// video test pattern pixel generator.
// ----------------------------------------------------------------------------
package vtp_pkg;

    localparam int COORD_W     = 12;
    localparam int FRAME_NUM_W = 8;
    localparam int COLOR_W     = 24;
    localparam int CH_W        = 8;
    localparam int MODE_W      = 3;
    localparam int FW_W        = 13;
    localparam int FC_W        = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;

    localparam int BAR_COUNT   = 8;
    localparam int BAR_SEL_W   = $clog2(BAR_COUNT);

    // checker tile = width / 12 via multiply by 2^19/12, floor exact for 13 bits
    localparam int TILE_W       = 10;
    localparam int TILE_MIN     = 32;
    localparam int TILE_RECIP   = 43691;
    localparam int TILE_RECIP_W = 16;
    localparam int TILE_SHIFT   = 19;
    localparam int TILE_PROD_W  = FW_W + TILE_RECIP_W;

    localparam int GRAD_NUM_W  = COORD_W + CH_W;
    localparam int PULSE_NUM_W = FRAME_NUM_W + CH_W;

    localparam int DIV_STAGES  = 4;
    localparam int PIPE_DEPTH  = DIV_STAGES + 2;

    localparam int WIDTH_RESET  = 1080;
    localparam int HEIGHT_RESET = 2400;
    localparam int COUNT_RESET  = 30;

    localparam logic [BAR_COUNT-1:0][COLOR_W-1:0] BAR_COLORS = {
        24'h202020, 24'h0000ff, 24'hff0000, 24'hff00ff,
        24'h00ff00, 24'h00ffff, 24'hffff00, 24'hffffff
    };
    localparam logic [COLOR_W-1:0] CHK_DARK   = 24'h101820;
    localparam logic [COLOR_W-1:0] CHK_LIGHT  = 24'hd8e8ff;
    localparam logic [CH_W-1:0]    PULSE_BLUE = 8'h40;
    localparam logic [CH_W-1:0]    CH_MAX     = 8'hff;

    typedef enum logic [MODE_W-1:0] {
        MODE_BARS     = 3'd0,
        MODE_CHECKER  = 3'd1,
        MODE_PULSE    = 3'd2,
        MODE_SOLID    = 3'd3,
        MODE_GRADIENT = 3'd4
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE   = 3'd0,
        REG_WIDTH  = 3'd1,
        REG_HEIGHT = 3'd2,
        REG_COUNT  = 3'd3,
        REG_SOLID  = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic [COORD_W-1:0]     pixel_x;
        logic [COORD_W-1:0]     pixel_y;
        logic [FRAME_NUM_W-1:0] frame_number;
    } coord_t;

    typedef struct packed {
        logic [COLOR_W-1:0] pixel_color;
    } color_t;

    // bar_thr[k] = (k+1) * bar width: bar index is the count of thresholds passed
    typedef logic [BAR_COUNT-2:0][FW_W-1:0] bar_thr_t;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        bar_thr_t           bar_thr;
        logic [TILE_W-1:0]  tile;
        logic [FW_W-1:0]    grad_den_x;
        logic [FW_W-1:0]    grad_den_y;
        logic [FC_W-1:0]    pulse_den;
        logic [COLOR_W-1:0] solid_color;
    } cfg_t;

    typedef struct packed {
        logic [PIPE_DEPTH-1:0] en;
        logic                  out_valid;
    } pipe_ctl_t;

    function automatic bar_thr_t f_bar_thr(input logic [FW_W-1:0] fw);
        logic [FW_W-1:0] bw;
        bar_thr_t        thr;
        bw = fw >> BAR_SEL_W;
        if (bw == '0)
        begin
            bw = FW_W'(1);
        end
        thr[0] = bw;
        for (int k = 1; k < BAR_COUNT - 1; k++)
        begin
            thr[k] = thr[k-1] + bw;
        end
        return thr;
    endfunction

    function automatic logic [TILE_W-1:0] f_tile(input logic [FW_W-1:0] fw);
        logic [TILE_PROD_W-1:0] prod;
        logic [TILE_W-1:0]      t;
        prod = TILE_PROD_W'(fw) * TILE_PROD_W'(TILE_RECIP);
        t = prod[TILE_SHIFT +: TILE_W];
        if (t < TILE_W'(TILE_MIN))
        begin
            t = TILE_W'(TILE_MIN);
        end
        return t;
    endfunction

    function automatic logic [FW_W-1:0] f_dim_den(input logic [FW_W-1:0] dim);
        return (dim > FW_W'(1)) ? dim - FW_W'(1) : FW_W'(1);
    endfunction

    function automatic logic [FC_W-1:0] f_count_den(input logic [FC_W-1:0] fc);
        return (fc > FC_W'(1)) ? fc - FC_W'(1) : FC_W'(1);
    endfunction

    function automatic cfg_t f_cfg_reset();
        cfg_t c;
        c.mode        = MODE_BARS;
        c.bar_thr     = f_bar_thr(FW_W'(WIDTH_RESET));
        c.tile        = f_tile(FW_W'(WIDTH_RESET));
        c.grad_den_x  = f_dim_den(FW_W'(WIDTH_RESET));
        c.grad_den_y  = f_dim_den(FW_W'(HEIGHT_RESET));
        c.pulse_den   = f_count_den(FC_W'(COUNT_RESET));
        c.solid_color = '0;
        return c;
    endfunction

endpackage

// ----- design/vtp_stream_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtp_stream_if
// Valid/ready stream channel; a request moves when valid and ready are high.
// ----------------------------------------------------------------------------
interface vtp_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- design/vtp_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtp_cfg_regs
// Configuration registers. Keeps only the values the datapath needs: mode,
// solid color, and bar thresholds, checker tile, ramp and pulse divisors derived at write time.
// ----------------------------------------------------------------------------
module vtp_cfg_regs
    import vtp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_MODE:
                begin
                    cfg_next.mode = cfg_wdata[MODE_W-1:0];
                end
                REG_WIDTH:
                begin
                    cfg_next.bar_thr    = f_bar_thr(cfg_wdata[FW_W-1:0]);
                    cfg_next.tile       = f_tile(cfg_wdata[FW_W-1:0]);
                    cfg_next.grad_den_x = f_dim_den(cfg_wdata[FW_W-1:0]);
                end
                REG_HEIGHT:
                begin
                    cfg_next.grad_den_y = f_dim_den(cfg_wdata[FW_W-1:0]);
                end
                REG_COUNT:
                begin
                    cfg_next.pulse_den = f_count_den(cfg_wdata[FC_W-1:0]);
                end
                REG_SOLID:
                begin
                    cfg_next.solid_color = cfg_wdata[COLOR_W-1:0];
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= f_cfg_reset();
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- design/vtp_div_pipe.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtp_div_pipe
// Pipelined restoring divider, a few quotient bits per stage. The divisor is
// a config value the user must hold while items are in flight (not enforced).
// Needs num < den << QUO_W for an exact quotient. STAGES must be at least 2.
// ----------------------------------------------------------------------------
module vtp_div_pipe
    import vtp_pkg::*;
#(
    parameter int NUM_W  = GRAD_NUM_W,
    parameter int DEN_W  = FW_W,
    parameter int QUO_W  = CH_W,
    parameter int STAGES = DIV_STAGES
)
(
    input  logic              clk,
    input  logic [STAGES-1:0] en,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    output logic [QUO_W-1:0]  quo
);

    localparam int STEPS = (QUO_W + STAGES - 1) / STAGES;
    localparam int EXT_W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

    logic [STAGES-2:0][EXT_W-1:0] rem_reg;
    logic [STAGES-1:0][QUO_W-1:0] quo_reg;

    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        logic [EXT_W-1:0] rem_c [STEPS+1];
        logic [QUO_W-1:0] quo_c [STEPS+1];

        if (s == 0)
        begin : g_first
            assign rem_c[0] = EXT_W'(num);
            assign quo_c[0] = '0;
        end
        else
        begin : g_next
            assign rem_c[0] = rem_reg[s-1];
            assign quo_c[0] = quo_reg[s-1];
        end

        for (genvar j = 0; j < STEPS; j++)
        begin : g_step
            localparam int BIT = QUO_W - 1 - (s * STEPS + j);
            if (BIT >= 0)
            begin : g_sub
                logic [EXT_W-1:0] dsh;
                logic             take;
                assign dsh          = EXT_W'(den) << BIT;
                assign take         = rem_c[j] >= dsh;
                assign rem_c[j+1]   = take ? rem_c[j] - dsh : rem_c[j];
                assign quo_c[j+1]   = quo_c[j] | (QUO_W'(take) << BIT);
            end
            else
            begin : g_pass
                assign rem_c[j+1] = rem_c[j];
                assign quo_c[j+1] = quo_c[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[s])
            begin
                quo_reg[s] <= quo_c[STEPS];
            end
        end

        // last stage only hands on the quotient
        if (s < STAGES - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en[s])
                begin
                    rem_reg[s] <= rem_c[STEPS];
                end
            end
        end
    end

    assign quo = quo_reg[STAGES-1];

endmodule

// ----- design/vtp_pipe_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtp_pipe_ctrl
// Valid bits and per-stage load enables. A stage loads when it is empty or
// its successor moves, so bubbles close up and a stall holds every request.
// ----------------------------------------------------------------------------
module vtp_pipe_ctrl
    import vtp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      up_valid,
    input  logic      down_ready,
    output pipe_ctl_t ctl
);

    logic [PIPE_DEPTH-1:0] vld_reg;
    logic [PIPE_DEPTH-1:0] vld_next;
    logic [PIPE_DEPTH-1:0] rdy;

    assign rdy[PIPE_DEPTH-1] = !vld_reg[PIPE_DEPTH-1] || down_ready;

    for (genvar i = 0; i < PIPE_DEPTH - 1; i++)
    begin : g_rdy
        assign rdy[i] = !vld_reg[i] || rdy[i+1];
    end

    for (genvar i = 0; i < PIPE_DEPTH; i++)
    begin : g_vld
        if (i == 0)
        begin : g_head
            assign vld_next[i] = rdy[i] ? up_valid : vld_reg[i];
        end
        else
        begin : g_body
            assign vld_next[i] = rdy[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign ctl.en        = rdy;
    assign ctl.out_valid = vld_reg[PIPE_DEPTH-1];

`ifndef ASSERT_OFF
    // empty output stage means the whole chain can move
    a_empty_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !vld_reg[PIPE_DEPTH-1] |-> rdy[0])
        else $error("input blocked with empty output stage");

    // only a completely full, stalled pipe may refuse input
    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        !rdy[0] |-> ((&vld_reg) && !down_ready))
        else $error("input blocked while a stage is free");

    // requests in flight change only by accepts on either side
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |->
        ($countones(vld_reg) == $countones($past(vld_reg))
            + ($past(up_valid && rdy[0]) ? 1 : 0)
            - ($past(vld_reg[PIPE_DEPTH-1] && down_ready) ? 1 : 0)))
        else $error("request lost or duplicated in pipeline");
`endif

endmodule

// ----- design/video_test_pattern_pixel.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// video_test_pattern_pixel
// Test pattern pixel generator: bars, checker, pulse, solid and gradient.
//
//   channel  dir  payload                                     handshake
//   coord    in   pixel_x[12], pixel_y[12], frame_number[8]   valid/ready
//   color    out  pixel_color[24]                             valid/ready
//   cfg      in   cfg_index[3], cfg_wdata[24]                 cfg_we, no wait
//
// One pixel per clock unless color stalls; pipeline: an operand stage, four stages of
// the restoring dividers (ramp, tile and fade quotients), an output register.
// Reset restores the default configuration and empties the pipeline; no
// clearing pass. A stall on color holds each stage; empty stages still fill,
// so coord is refused only when all six stages are full.
// ----------------------------------------------------------------------------
module video_test_pattern_pixel
    import vtp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    vtp_stream_if.sink            coord,
    vtp_stream_if.source          color
);

    typedef struct packed {
        logic [BAR_SEL_W-1:0] bar_sel;
        logic                 chk_par;
        logic [CH_W-1:0]      blue;
        logic                 sat_x;
        logic                 sat_y;
    } side_t;

    cfg_t      cfg;
    pipe_ctl_t ctl;
    coord_t    req;

    vtp_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    vtp_pipe_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (coord.valid),
        .down_ready (color.ready),
        .ctl        (ctl)
    );

    assign req         = coord.data;
    assign coord.ready = ctl.en[0];
    assign color.valid = ctl.out_valid;

    // ---------------- operand stage ----------------
    logic [BAR_COUNT-2:0]   bar_hit;
    logic [BAR_SEL_W-1:0]   bar_idx;
    logic [GRAD_NUM_W-1:0]  x255;
    logic [GRAD_NUM_W-1:0]  y255;
    logic [PULSE_NUM_W-1:0] f255;
    logic                   is_chk;
    logic [FW_W-1:0]        den_a;
    logic [FW_W-1:0]        den_b;
    side_t                  side_next;

    for (genvar k = 0; k < BAR_COUNT - 1; k++)
    begin : g_bar
        assign bar_hit[k] = FW_W'(req.pixel_x) >= cfg.bar_thr[k];
    end

    // thresholds rise, so the hit count is the bar index capped at the last bar
    assign bar_idx = BAR_SEL_W'($countones(bar_hit));

    assign x255 = {req.pixel_x, {CH_W{1'b0}}} - GRAD_NUM_W'(req.pixel_x);
    assign y255 = {req.pixel_y, {CH_W{1'b0}}} - GRAD_NUM_W'(req.pixel_y);
    assign f255 = {req.frame_number, {CH_W{1'b0}}} - PULSE_NUM_W'(req.frame_number);

    // checker and gradient share the x and y dividers; user must hold mode while busy, not enforced
    assign is_chk = (cfg.mode == MODE_CHECKER);
    assign den_a  = is_chk ? FW_W'(cfg.tile) : cfg.grad_den_x;
    assign den_b  = is_chk ? FW_W'(cfg.tile) : cfg.grad_den_y;

    always_comb
    begin
        side_next.bar_sel = bar_idx + req.frame_number[BAR_SEL_W-1:0];
        side_next.chk_par = req.frame_number[0];
        side_next.blue    = req.pixel_x[CH_W-1:0] ^ req.pixel_y[CH_W-1:0];
        // ramp saturates once x*255 >= den*256
        side_next.sat_x   = FW_W'(x255[GRAD_NUM_W-1:CH_W]) >= cfg.grad_den_x;
        side_next.sat_y   = FW_W'(y255[GRAD_NUM_W-1:CH_W]) >= cfg.grad_den_y;
    end

    logic [GRAD_NUM_W-1:0]     num_a_reg;
    logic [GRAD_NUM_W-1:0]     num_b_reg;
    logic [PULSE_NUM_W-1:0]    num_c_reg;
    side_t [DIV_STAGES:0]      side_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.en[0])
        begin
            num_a_reg   <= is_chk ? GRAD_NUM_W'(req.pixel_x) : x255;
            num_b_reg   <= is_chk ? GRAD_NUM_W'(req.pixel_y) : y255;
            num_c_reg   <= f255;
            side_reg[0] <= side_next;
        end
    end

    // ---------------- divider stages ----------------
    for (genvar s = 1; s <= DIV_STAGES; s++)
    begin : g_side
        always_ff @(posedge clk)
        begin
            if (ctl.en[s])
            begin
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    logic [CH_W-1:0]        quo_a;
    logic [CH_W-1:0]        quo_b;
    logic [PULSE_NUM_W-1:0] quo_c;

    vtp_div_pipe #(
        .NUM_W  (GRAD_NUM_W),
        .DEN_W  (FW_W),
        .QUO_W  (CH_W),
        .STAGES (DIV_STAGES)
    ) u_div_x (
        .clk (clk),
        .en  (ctl.en[DIV_STAGES:1]),
        .num (num_a_reg),
        .den (den_a),
        .quo (quo_a)
    );

    vtp_div_pipe #(
        .NUM_W  (GRAD_NUM_W),
        .DEN_W  (FW_W),
        .QUO_W  (CH_W),
        .STAGES (DIV_STAGES)
    ) u_div_y (
        .clk (clk),
        .en  (ctl.en[DIV_STAGES:1]),
        .num (num_b_reg),
        .den (den_b),
        .quo (quo_b)
    );

    vtp_div_pipe #(
        .NUM_W  (PULSE_NUM_W),
        .DEN_W  (FC_W),
        .QUO_W  (PULSE_NUM_W),
        .STAGES (DIV_STAGES)
    ) u_div_fade (
        .clk (clk),
        .en  (ctl.en[DIV_STAGES:1]),
        .num (num_c_reg),
        .den (cfg.pulse_den),
        .quo (quo_c)
    );

    // ---------------- output stage ----------------
    side_t              sd;
    logic [COLOR_W-1:0] color_next;
    logic [COLOR_W-1:0] color_reg;

    assign sd = side_reg[DIV_STAGES];

    always_comb
    begin
        case (cfg.mode)
            MODE_BARS:
            begin
                color_next = BAR_COLORS[sd.bar_sel];
            end
            MODE_CHECKER:
            begin
                color_next = (quo_a[0] ^ quo_b[0] ^ sd.chk_par) ? CHK_DARK : CHK_LIGHT;
            end
            MODE_PULSE:
            begin
                color_next = {quo_c[CH_W-1:0], ~quo_c[CH_W-1:0], PULSE_BLUE};
            end
            MODE_SOLID:
            begin
                color_next = cfg.solid_color;
            end
            MODE_GRADIENT:
            begin
                color_next = {sd.blue,
                              sd.sat_y ? CH_MAX : quo_b,
                              sd.sat_x ? CH_MAX : quo_a};
            end
            default:
            begin
                color_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en[PIPE_DEPTH-1])
        begin
            color_reg <= color_next;
        end
    end

    assign color.data.pixel_color = color_reg;

endmodule
